// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the console writer.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent property sampled on the rising clock, off while in reset.
`define TCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication: cons must hold whenever ante holds.
`define TCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types, constants and helpers for the text console writer.
// No dependencies; every other module imports it.
package tcw_pkg;

  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned ADDR_W = $clog2(CELLS);

  localparam int unsigned POS_W  = 11;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned TERM_W = 2;

  localparam int unsigned IN_FIELDS_W  = CHAR_W + IDX_W;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned IN_USER_W    = 2;
  localparam int unsigned OUT_FIELDS_W = POS_W + CHAR_W + ATTR_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PROMPT_A  = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_PROMPT_B  = 8'h3F;

  localparam logic [ATTR_W-1:0] ATTR_RED    = 8'h04;
  localparam logic [ATTR_W-1:0] ATTR_YELLOW = 8'h0E;
  localparam logic [ATTR_W-1:0] ATTR_GREEN  = 8'h0A;
  localparam logic [ATTR_W-1:0] ATTR_AQUA   = 8'h0B;
  localparam logic [ATTR_W-1:0] ATTR_WHITE  = 8'h0F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TERMINAL_ID    = 2'd0,
    CFG_COLOR_OVERRIDE = 2'd1,
    CFG_CLEAR_PENDING  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_BACKSPACE,
    OP_NEWLINE,
    OP_READ
  } op_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRIME,
    ST_SCROLL,
    ST_BACK,
    ST_READ
  } eng_state_e;

  typedef struct packed {
    op_kind_e            kind;
    logic [CHAR_W-1:0]   char_code;
    logic                kernel_output;
    logic [IDX_W-1:0]    cell_index;
  } op_t;

  typedef struct packed {
    logic clearing;
  } eng_status_t;

  typedef struct packed {
    logic [ATTR_W-1:0] read_attr;
    logic [CHAR_W-1:0] read_char;
    logic [POS_W-1:0]  cursor_position;
  } result_t;

  function automatic logic [ATTR_W-1:0] term_colour(input logic [TERM_W-1:0] term);
    logic [ATTR_W-1:0] colour;
    unique case (term)
      2'd1:    colour = ATTR_YELLOW;
      2'd2:    colour = ATTR_GREEN;
      2'd3:    colour = ATTR_AQUA;
      default: colour = ATTR_WHITE;
    endcase
    return colour;
  endfunction

  function automatic logic [ADDR_W-1:0] lin_pos(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return ADDR_W'(32'(row) * COLUMNS + 32'(col));
  endfunction

endpackage

// ===== rtl/tcw_front.sv =====
// Front end: accepts stream items, sorts them into operation kinds and
// buffers them in a two-entry queue. Depends on tcw_pkg.
module tcw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tcw_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [tcw_pkg::IN_USER_W-1:0] s_axis_tuser,
  input  tcw_pkg::eng_status_t          status_i,
  output logic                          op_valid_o,
  output tcw_pkg::op_t                  op_o,
  input  logic                          op_pop_i
);
  import tcw_pkg::*;

  op_t        entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  op_t        op_new;
  logic       push;

  // Sort the incoming item.
  always_comb begin
    op_new.char_code     = s_axis_tdata[CHAR_W-1:0];
    op_new.cell_index    = s_axis_tdata[CHAR_W +: IDX_W];
    op_new.kernel_output = s_axis_tuser[1];
    if (cmd_e'(s_axis_tuser[0]) == CMD_READ) begin
      op_new.kind = OP_READ;
    end else begin
      case (op_new.char_code) inside
        CH_BACKSPACE:          op_new.kind = OP_BACKSPACE;
        CH_NEWLINE, CH_RETURN: op_new.kind = OP_NEWLINE;
        default:               op_new.kind = OP_PUT;
      endcase
    end
  end

  // Hold off the source while full or while the store is being cleared.
  assign s_axis_tready = (count_q != 2'd2) && !status_i.clearing;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign op_valid_o    = (count_q != 2'd0);
  assign op_o          = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (op_pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !op_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && op_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

// ===== rtl/tcw_engine.sv =====
// Back end: owns the cell store, the cursor and the wrap flag, carries out
// queued operations and drives the result register. Depends on tcw_pkg.
module tcw_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tcw_pkg::TERM_W-1:0] terminal_id_i,
  input  logic                       color_override_i,
  input  logic                       clear_pending_i,
  input  logic                       op_valid_i,
  input  tcw_pkg::op_t               op_i,
  output logic                       op_pop_o,
  output tcw_pkg::eng_status_t       status_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output tcw_pkg::result_t           res_o
);
  import tcw_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ROW_ONE   = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] SRC_STEP  = ADDR_W'(COLUMNS + 1);
  localparam logic [ADDR_W-1:0] TWO_BACK  = ADDR_W'(2);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  logic [CHAR_W-1:0] char_mem [CELLS];
  logic [ATTR_W-1:0] attr_mem [CELLS];

  eng_state_e        state_q, state_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              wrapped_q, wrapped_d;
  logic [ATTR_W-1:0] fill_q, fill_d;
  logic              chk_q, chk_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              wr_char_en, wr_attr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CHAR_W-1:0] wr_char;
  logic [ATTR_W-1:0] wr_attr;
  logic [CHAR_W-1:0] rd_char_q;
  logic [ATTR_W-1:0] rd_attr_q;

  logic              out_load;
  logic              out_free;
  logic [ADDR_W-1:0] pos_cur;
  logic [ATTR_W-1:0] put_attr, colour;
  logic              last_col, last_row, prompt, do_write, do_line;

  assign pos_cur  = lin_pos(row_q, col_q);
  assign last_col = (col_q == LAST_COL);
  assign last_row = (row_q == LAST_ROW);
  assign out_free = !out_valid_q || res_ready_i;
  assign colour   = term_colour(terminal_id_i);
  assign put_attr = (clear_pending_i || color_override_i || !op_i.kernel_output) ?
                    colour : ATTR_RED;
  assign prompt   = chk_q && ((rd_char_q == CH_PROMPT_A) || (rd_char_q == CH_PROMPT_B));

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    row_d      = row_q;
    col_d      = col_q;
    wrapped_d  = wrapped_q;
    fill_d     = fill_q;
    chk_d      = chk_q;
    op_pop_o   = 1'b0;
    wr_char_en = 1'b0;
    wr_attr_en = 1'b0;
    wr_addr    = pos_cur;
    wr_char    = op_i.char_code;
    wr_attr    = put_attr;
    rd_en      = 1'b0;
    rd_addr    = ADDR_W'(op_i.cell_index);
    out_load   = 1'b0;
    out_d      = out_q;
    out_d.read_char = '0;
    out_d.read_attr = '0;
    do_write   = 1'b0;
    do_line    = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        wr_char_en = 1'b1;
        wr_attr_en = 1'b1;
        wr_addr    = sweep_q;
        wr_char    = '0;
        wr_attr    = '0;
        if (sweep_q == LAST_CELL) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (op_valid_i && out_free) begin
          op_pop_o = 1'b1;
          fill_d   = (!color_override_i && op_i.kernel_output) ? ATTR_RED : colour;
          unique case (op_i.kind)
            OP_READ: begin
              if (32'(op_i.cell_index) < CELLS) begin
                rd_en   = 1'b1;
                state_d = ST_READ;
              end else begin
                out_load = 1'b1;
              end
            end
            OP_BACKSPACE: begin
              // Look two cells back for a prompt character.
              chk_d   = (pos_cur >= TWO_BACK);
              rd_en   = (pos_cur >= TWO_BACK);
              rd_addr = pos_cur - TWO_BACK;
              state_d = ST_BACK;
            end
            OP_PUT, OP_NEWLINE: begin
              // At the last column even a newline byte lands in the cell.
              do_write = (op_i.kind == OP_PUT) || last_col;
              do_line  = (op_i.kind == OP_NEWLINE) || last_col;
              wr_char_en = do_write;
              wr_attr_en = do_write;
              if (last_col) begin
                wrapped_d = 1'b1;
              end
              if (do_line) begin
                col_d = '0;
                if (!last_row) begin
                  row_d    = row_q + ROW_W'(1);
                  out_load = 1'b1;
                end else begin
                  state_d = ST_PRIME;
                end
              end else begin
                col_d    = col_q + COL_W'(1);
                out_load = 1'b1;
              end
            end
          endcase
        end
      end

      ST_PRIME: begin
        rd_en   = 1'b1;
        rd_addr = ROW_ONE;
        sweep_d = '0;
        state_d = ST_SCROLL;
      end

      ST_SCROLL: begin
        // Move each cell up one row, then blank the bottom row.
        wr_char_en = 1'b1;
        wr_attr_en = 1'b1;
        wr_addr    = sweep_q;
        if (sweep_q < COPY_END) begin
          wr_char = rd_char_q;
          wr_attr = rd_attr_q;
          rd_en   = (sweep_q < COPY_LAST);
          rd_addr = sweep_q + SRC_STEP;
        end else begin
          wr_char = '0;
          wr_attr = fill_q;
        end
        if (sweep_q == LAST_CELL) begin
          sweep_d  = '0;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          sweep_d = sweep_q + ADDR_W'(1);
        end
      end

      ST_BACK: begin
        wr_char = CH_SPACE;
        if (!prompt) begin
          if (col_q == '0 && wrapped_q) begin
            if (row_q != '0) begin
              row_d = row_q - ROW_W'(1);
            end
            col_d      = LAST_COL;
            wrapped_d  = 1'b0;
            wr_char_en = 1'b1;
          end else if (col_q != '0) begin
            col_d      = col_q - COL_W'(1);
            wr_char_en = 1'b1;
          end
        end
        wr_addr  = lin_pos(row_d, col_d);
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end

      ST_READ: begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase

    if (state_q == ST_READ) begin
      out_d.read_char = rd_char_q;
      out_d.read_attr = rd_attr_q;
    end
    out_d.cursor_position = POS_W'(lin_pos(row_d, col_d));

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      wrapped_q   <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      row_q       <= row_d;
      col_q       <= col_d;
      wrapped_q   <= wrapped_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Cell store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_char_en) begin
      char_mem[wr_addr] <= wr_char;
    end
    if (wr_attr_en) begin
      attr_mem[wr_addr] <= wr_attr;
    end
    if (rd_en) begin
      rd_char_q <= char_mem[rd_addr];
      rd_attr_q <= attr_mem[rd_addr];
    end
  end

  assign status_o.clearing = (state_q == ST_CLEAR);
  assign res_valid_o       = out_valid_q;
  assign res_o             = out_q;

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: configuration registers, front end,
// queue and execution back end. Depends on tcw_pkg, tcw_front, tcw_engine.
//
//   Channel   Direction  Signals                         Carries
//   s_axis    in         tvalid/tready/tdata/tuser       put or read request
//   m_axis    out        tvalid/tready/tdata             cursor and read cell
//   cfg       in         cfg_we_i/cfg_index_i/cfg_wdata_i  register writes
//
// A put, newline or out-of-range read loads the result register straight from
// the idle state unless it scrolls; an in-range read or a backspace passes
// through ST_READ or ST_BACK first (store read). A newline or wrap past the
// bottom row scrolls the store cell by cell in ST_PRIME and ST_SCROLL. After
// reset the store clears one cell a cycle with s_axis_tready low. A stalled
// result holds while the queue keeps taking up to two more requests.
module text_console_writer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Request stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: char_code[7:0], cell_index[18:8], zero pad above
  input  logic [tcw_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: command[0], kernel_output[1]
  input  logic [tcw_pkg::IN_USER_W-1:0]  s_axis_tuser,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: cursor_position[10:0], read_char[18:11], read_attr[26:19], zero pad
  output logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration writes.
  input  logic                           cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tcw_pkg::*;

  logic [TERM_W-1:0] terminal_id_q, terminal_id_d;
  logic              color_override_q, color_override_d;
  logic              clear_pending_q, clear_pending_d;

  eng_status_t eng_status;
  op_t         queue_op;
  logic        queue_valid;
  logic        queue_pop;
  result_t     result;

  // Decode register writes; indexes beyond the list are dropped.
  always_comb begin
    terminal_id_d    = terminal_id_q;
    color_override_d = color_override_q;
    clear_pending_d  = clear_pending_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TERMINAL_ID:    terminal_id_d    = cfg_wdata_i[TERM_W-1:0];
        CFG_COLOR_OVERRIDE: color_override_d = cfg_wdata_i[0];
        CFG_CLEAR_PENDING:  clear_pending_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      terminal_id_q    <= TERM_W'(1);
      color_override_q <= 1'b0;
      clear_pending_q  <= 1'b0;
    end else begin
      terminal_id_q    <= terminal_id_d;
      color_override_q <= color_override_d;
      clear_pending_q  <= clear_pending_d;
    end
  end

  // Accept and sort requests.
  tcw_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .status_i      (eng_status),
    .op_valid_o    (queue_valid),
    .op_o          (queue_op),
    .op_pop_i      (queue_pop)
  );

  // Carry out requests against the cell store.
  tcw_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .terminal_id_i    (terminal_id_q),
    .color_override_i (color_override_q),
    .clear_pending_i  (clear_pending_q),
    .op_valid_i       (queue_valid),
    .op_i             (queue_op),
    .op_pop_o         (queue_pop),
    .status_o         (eng_status),
    .res_valid_o      (m_axis_tvalid),
    .res_ready_i      (m_axis_tready),
    .res_o            (result)
  );

  // Pack fields lowest first, pad with zeros.
  assign m_axis_tdata = OUT_DATA_W'(result);

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checker for the text console writer, bound to the top level.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tcw_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import tcw_pkg::*;

  logic [2:0] pend_q;
  logic       in_acc, out_acc, out_stall, cursor_ok;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign cursor_ok = (32'(m_axis_tdata[POS_W-1:0]) < CELLS);

  // Count requests taken whose results are not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 3'd1;
    end else if (!in_acc && out_acc) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  `TCW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid, "result dropped")
  `TCW_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(m_axis_tdata), "data moved")
  `TCW_ASSERT_IMPL(a_no_extra, clk_i, rst_ni, m_axis_tvalid, pend_q != 3'd0, "unrequested result")
  `TCW_ASSERT(a_bounded, clk_i, rst_ni, pend_q <= 3'd4, "too many requests in flight")
  `TCW_ASSERT_IMPL(a_cursor_range, clk_i, rst_ni, m_axis_tvalid, cursor_ok, "cursor off screen")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
